/* rtl/lmfb_pkg.sv */
// LIN master frame builder: shared types, kind codes and constants.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lmfb_pkg;

   // Largest data length accepted (1 to 8, the bytes the request can carry)
   localparam int unsigned LMFB_MAX_BYTES = 8;

   localparam int unsigned LEN_W  = 4;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned DATA_W = 64;
   localparam int unsigned KIND_W = 3;

   // Result kind codes
   localparam logic [KIND_W-1:0] KIND_BREAK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SYNC     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ID       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DATA     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CHECKSUM = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LENERR   = 3'd5;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
   localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

   typedef struct packed {
      logic [BYTE_W-1:0] ident;
      logic [LEN_W-1:0]  byte_count;
      logic [DATA_W-1:0] data_bytes;
   } lmfb_req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      logic              last;
   } lmfb_rsp_type;

   // Control from the sequencer to the checksum accumulator
   typedef struct packed {
      logic              clear;
      logic              add;
      logic [BYTE_W-1:0] operand;
   } lmfb_sum_ctl_type;

endpackage

/* rtl/lin_master_frame_builder_top.sv */
// Top level of the LIN master frame builder: sequencer plus checksum accumulator.
// Depends on lmfb_pkg, lmfb_seq and lmfb_sum_unit.
`timescale 1ns / 1ps

// A request (identifier, data length, up to eight data bytes) is taken when
// start is high and busy is low. A valid length of N bytes yields N+4 results,
// one per cycle: break, sync 0x55, identifier, the data bytes, and the classic
// checksum marked last; a length of 0 or above the maximum yields one length
// error result marked last. Results appear for one cycle each with rsp_valid
// high and must be taken then: the receiver cannot stall. The first result is
// on the ports after the accepting edge has loaded the sequencer state and the
// result register has then captured it. The sequencer steps one result per
// cycle, with a single shared checksum adder folding in one data byte per data
// result. busy drops during the cycle the last result is shown, so the next
// request can be taken at its end.
module lin_master_frame_builder_top #(
   parameter int unsigned MAX_BYTES = lmfb_pkg::LMFB_MAX_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lmfb_pkg::lmfb_req_type req_data,
   output logic                   rsp_valid,
   output lmfb_pkg::lmfb_rsp_type rsp_data
);
   import lmfb_pkg::*;

   lmfb_sum_ctl_type  sum_ctl;
   logic [BYTE_W-1:0] sum;

   lmfb_seq #(
      .MAX_BYTES (MAX_BYTES)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .sum_ctl   (sum_ctl),
      .sum       (sum)
   );

   lmfb_sum_unit u_sum (
      .clock (clock),
      .reset (reset),
      .ctl   (sum_ctl),
      .sum   (sum)
   );

endmodule

/* rtl/lmfb_sum_unit.sv */
// Checksum accumulator: one 8-bit adder with end-around carry, reused per data byte.
// Depends on lmfb_pkg.
`timescale 1ns / 1ps

module lmfb_sum_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  lmfb_pkg::lmfb_sum_ctl_type ctl,
   output logic [7:0]               sum
);
   import lmfb_pkg::*;

   logic [BYTE_W-1:0] sum_ff;
   logic [BYTE_W-1:0] sum_in;
   logic [BYTE_W:0]   wide_sum;

   // Add the operand and fold the carry back in at bit 0
   always_comb begin
      wide_sum = {1'b0, sum_ff} + {1'b0, ctl.operand};
      sum_in   = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.add) begin
         sum_in = wide_sum[BYTE_W-1:0] + BYTE_W'(wide_sum[BYTE_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

/* rtl/lmfb_seq.sv */
// Frame sequencer: walks break, sync, identifier, data bytes and checksum, or a
// length error, one result per cycle. Depends on lmfb_pkg.
`timescale 1ns / 1ps

module lmfb_seq #(
   parameter int unsigned MAX_BYTES = lmfb_pkg::LMFB_MAX_BYTES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lmfb_pkg::lmfb_req_type     req,
   output logic                       rsp_valid,
   output lmfb_pkg::lmfb_rsp_type     rsp_data,
   output lmfb_pkg::lmfb_sum_ctl_type sum_ctl,
   input  logic [7:0]                 sum
);
   import lmfb_pkg::*;

   // Lengths are capped at the bytes a request can carry
   localparam int unsigned LEN_LIMIT =
      (MAX_BYTES > DATA_W / BYTE_W) ? DATA_W / BYTE_W : MAX_BYTES;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_BREAK  = 3'd1;
   localparam logic [2:0] ST_SYNC   = 3'd2;
   localparam logic [2:0] ST_ID     = 3'd3;
   localparam logic [2:0] ST_DATA   = 3'd4;
   localparam logic [2:0] ST_CSUM   = 3'd5;
   localparam logic [2:0] ST_LENERR = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lmfb_rsp_type      rsp_ff, rsp_in;
   logic              accept;
   logic              len_bad;

   assign accept  = start && (state_ff == ST_IDLE);
   assign len_bad = (req.byte_count == '0) || (req.byte_count > LEN_W'(LEN_LIMIT));

   // Advance the sequence and build the next result
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      id_in        = id_ff;
      data_in      = data_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      sum_ctl      = '{clear: 1'b0, add: 1'b0, operand: data_ff[BYTE_W-1:0]};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               id_in         = req.ident;
               data_in       = req.data_bytes;
               cnt_in        = req.byte_count;
               sum_ctl.clear = 1'b1;
               state_in      = len_bad ? ST_LENERR : ST_BREAK;
            end
         end
         ST_LENERR: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: KIND_LENERR, value: '0, last: 1'b1};
            state_in     = ST_IDLE;
         end
         ST_BREAK: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: KIND_BREAK, value: '0, last: 1'b0};
            state_in     = ST_SYNC;
         end
         ST_SYNC: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: KIND_SYNC, value: SYNC_BYTE, last: 1'b0};
            state_in     = ST_ID;
         end
         ST_ID: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: KIND_ID, value: id_ff, last: 1'b0};
            state_in     = ST_DATA;
         end
         ST_DATA: begin
            // Emit the low byte, fold it into the checksum, shift the rest down
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: KIND_DATA, value: data_ff[BYTE_W-1:0], last: 1'b0};
            sum_ctl.add  = 1'b1;
            data_in      = data_ff >> BYTE_W;
            cnt_in       = cnt_ff - LEN_W'(1);
            if (cnt_ff == LEN_W'(1)) begin
               state_in = ST_CSUM;
            end
         end
         ST_CSUM: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{kind: KIND_CHECKSUM, value: sum ^ BYTE_ONES, last: 1'b1};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      id_ff   <= id_in;
      data_ff <= data_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> state_ff == ST_IDLE)
      else $error("last result shown while frame still in progress");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid_ff)
      else $error("accepted request gave no first result");

   a_csum_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.kind == KIND_CHECKSUM || rsp_ff.kind == KIND_LENERR)
      |-> rsp_ff.last)
      else $error("checksum or length error not marked last");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !start |=> !rsp_valid_ff)
      else $error("result emitted with no request in progress");
`endif

endmodule

/* tb/sv/lmfb_frame_checker.sv */
// Checker for the LIN master frame builder: watches the request and result channels,
// expands each accepted frame request into its expected bytes and compares results.
// Depends on lmfb_pkg for the request/result structs and the kind codes.
`timescale 1ns / 1ps

module lmfb_frame_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  lmfb_pkg::lmfb_req_type req,
   input  logic                   rsp_valid,
   input  lmfb_pkg::lmfb_rsp_type rsp_data,
   output int unsigned            mismatch_count,
   output int unsigned            bytes_pending,
   output int unsigned            bytes_checked
);
   import lmfb_pkg::*;

   // Expected results, oldest first
   lmfb_rsp_type frame_bytes_q[$];

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Classic LIN checksum: sum with end-around carry, then invert
   function automatic logic [BYTE_W-1:0] classic_checksum(input logic [DATA_W-1:0] bytes,
                                                          input int unsigned count);
      logic [BYTE_W:0] acc;
      acc = '0;
      for (int unsigned n = 0; n < count; n++) begin
         acc = acc + bytes[n*BYTE_W +: BYTE_W];
         if (acc > BYTE_ONES)
            acc = acc - BYTE_ONES;
      end
      return acc[BYTE_W-1:0] ^ BYTE_ONES;
   endfunction

   // Expand one frame request into the results the bus master would send
   function automatic void expand_frame(input lmfb_req_type r);
      int unsigned count;
      count = 32'(r.byte_count);
      if (count < 1 || count > LMFB_MAX_BYTES) begin
         frame_bytes_q.push_back('{KIND_LENERR, 8'h00, 1'b1});
         return;
      end
      frame_bytes_q.push_back('{KIND_BREAK, 8'h00, 1'b0});
      frame_bytes_q.push_back('{KIND_SYNC, SYNC_BYTE, 1'b0});
      frame_bytes_q.push_back('{KIND_ID, r.ident, 1'b0});
      for (int unsigned n = 0; n < count; n++)
         frame_bytes_q.push_back('{KIND_DATA, r.data_bytes[n*BYTE_W +: BYTE_W], 1'b0});
      frame_bytes_q.push_back('{KIND_CHECKSUM, classic_checksum(r.data_bytes, count), 1'b1});
   endfunction

   // Predict on each accepted request, compare each strobed result
   always @(posedge clock) begin
      lmfb_rsp_type want;
      if (reset) begin
         frame_bytes_q.delete();
      end else begin
         if (rsp_valid) begin
            if (frame_bytes_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind=%0d value=%02h last=%0b",
                                         rsp_data.kind, rsp_data.value, rsp_data.last));
            end else begin
               want = frame_bytes_q.pop_front();
               if (rsp_data.kind !== want.kind)
                  report_mismatch($sformatf("kind got %0d want %0d",
                                            rsp_data.kind, want.kind));
               if (rsp_data.value !== want.value)
                  report_mismatch($sformatf("value got %02h want %02h (kind %0d)",
                                            rsp_data.value, want.value, want.kind));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last got %0b want %0b (kind %0d)",
                                            rsp_data.last, want.last, want.kind));
               bytes_checked++;
            end
         end
         if (start && !busy)
            expand_frame(req);
      end
      bytes_pending <= frame_bytes_q.size();
   end

endmodule

/* tb/sv/lin_master_frame_builder_top_tb.sv */
// Testbench top for the LIN master frame builder: clock, reset, frame request stimulus,
// stall watchdog and verdict. Depends on lmfb_pkg, lmfb_frame_checker and the block's RTL.
`timescale 1ns / 1ps

module lin_master_frame_builder_top_tb;
   import lmfb_pkg::*;

   localparam int unsigned RANDOM_FRAMES = 360;
   localparam int unsigned STALL_LIMIT   = 500;
   localparam int unsigned DRAIN_CYCLES  = 16;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   lmfb_req_type req;
   logic         rsp_valid;
   lmfb_rsp_type rsp_data;

   int unsigned  mismatch_count;
   int unsigned  bytes_pending;
   int unsigned  bytes_checked;
   int unsigned  frames_sent;
   int unsigned  len_errors_sent;
   int unsigned  stall_cycles;
   bit           idle_on;

   lin_master_frame_builder_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   lmfb_frame_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req            (req),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending),
      .bytes_checked  (bytes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // End the run if neither channel moves for too long
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // Present one frame request, optionally after an idle gap, and hold it until taken
   task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                             input logic [DATA_W-1:0] bytes);
      int unsigned gap;
      gap = 0;
      if (idle_on && $urandom_range(99) < 36)
         gap = $urandom_range(1, 16);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req   <= '{ident: id, byte_count: len, data_bytes: bytes};
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      frames_sent++;
      if (len < 1 || len > LMFB_MAX_BYTES)
         len_errors_sent++;
   endtask

   function automatic logic [DATA_W-1:0] random_bytes();
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [LEN_W-1:0] len;
      frames_sent     = 0;
      len_errors_sent = 0;
      idle_on         = 1'b1;
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: length errors, extremes of id and data, every valid length
      send_frame(8'h00, 4'd0, 64'h0);
      send_frame(8'hFF, 4'd9, {64{1'b1}});
      send_frame(8'hA5, 4'd15, random_bytes());
      send_frame(8'h00, 4'd1, 64'h0);
      send_frame(8'hFF, 4'd1, 64'hFF);
      send_frame(8'h3C, 4'd8, {64{1'b1}});
      send_frame(8'hC3, 4'd8, 64'h0);
      // carry out of bit 7 folded back in
      send_frame(8'h12, 4'd2, 64'h8080);
      send_frame(8'h34, 4'd2, 64'h01FF);
      // bytes beyond the length must be ignored
      send_frame(8'h56, 4'd1, 64'hFFFF_FFFF_FFFF_FF00);
      send_frame(8'h78, 4'd3, 64'hDEAD_BEEF_CA00_0000);
      for (int unsigned n = 1; n <= LMFB_MAX_BYTES; n++)
         send_frame(BYTE_W'($urandom_range(255)), n[LEN_W-1:0], random_bytes());

      // Random: mostly valid frames, some bad lengths, one long stretch with no idling
      for (int unsigned i = 0; i < RANDOM_FRAMES; i++) begin
         idle_on = !(i >= 150 && i < 250);
         if ($urandom_range(99) < 15)
            len = ($urandom_range(3) == 0) ? 4'd0 : LEN_W'($urandom_range(9, 15));
         else
            len = LEN_W'($urandom_range(1, LMFB_MAX_BYTES));
         send_frame(BYTE_W'($urandom_range(255)), len, random_bytes());
      end
      start <= 1'b0;

      // Drain outstanding results, then allow a few cycles for strays
      @(posedge clock);
      while (bytes_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d frame requests (%0d with bad length), %0d results checked",
               frames_sent, len_errors_sent, bytes_checked);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
